[design/kdb_pkg.sv]
// ----------------------------------------------------------------------------
// kdb_pkg
// Shared types and constants for the key debounce and press-length detector.
// ----------------------------------------------------------------------------
package kdb_pkg;

	localparam int TIME_BITS_DEFAULT = 48;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_DEFAULT = 16'd30;
	localparam logic [CFG_DATA_BITS-1:0] LONG_PRESS_DEFAULT = 16'd800;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_LONG_PRESS = 2'd1,
		REG_PRESSED_LEVEL = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG = 2'd2
	} event_t;

	// Effective settings, with the zero-means-default rule already applied.
	typedef struct packed {
		logic [CFG_DATA_BITS-1:0] debounce;
		logic [CFG_DATA_BITS-1:0] long_press;
		logic pressed_level;
	} cfg_t;

endpackage

[design/kdb_cfg.sv]
// ----------------------------------------------------------------------------
// kdb_cfg
// Configuration registers and their effective values.
// ----------------------------------------------------------------------------
module kdb_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [kdb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [kdb_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	output kdb_pkg::cfg_t cfg
);

	logic [kdb_pkg::CFG_DATA_BITS-1:0] debounce_q;
	logic [kdb_pkg::CFG_DATA_BITS-1:0] long_press_q;
	logic pressed_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= kdb_pkg::DEBOUNCE_DEFAULT;
			long_press_q <= kdb_pkg::LONG_PRESS_DEFAULT;
			pressed_level_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (kdb_pkg::cfg_reg_t'(cfg_index))
				kdb_pkg::REG_DEBOUNCE: debounce_q <= cfg_wdata;
				kdb_pkg::REG_LONG_PRESS: long_press_q <= cfg_wdata;
				kdb_pkg::REG_PRESSED_LEVEL: pressed_level_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.debounce = (debounce_q == '0) ? kdb_pkg::DEBOUNCE_DEFAULT : debounce_q;
		cfg.long_press = (long_press_q == '0) ? kdb_pkg::LONG_PRESS_DEFAULT : long_press_q;
		cfg.pressed_level = pressed_level_q;
	end

endmodule

[design/kdb_core.sv]
// ----------------------------------------------------------------------------
// kdb_core
// Debounce state and the per-sample commit and press-length decision.
// ----------------------------------------------------------------------------
module kdb_core #(
	parameter int TIME_BITS = kdb_pkg::TIME_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic level,
	input logic [TIME_BITS-1:0] now,
	input kdb_pkg::cfg_t cfg,
	output kdb_pkg::event_t press_event
);

	logic stable_known_q;
	logic stable_state_q;
	logic raw_state_q;
	logic [TIME_BITS-1:0] raw_change_time_q;
	logic [TIME_BITS-1:0] press_start_time_q;

	logic [TIME_BITS:0] raw_age;
	logic [TIME_BITS:0] hold_len;
	logic commit;
	logic commit_press;
	logic is_long;

	// A changed level restarts the hold with zero age, so it can never commit
	// in the same sample; only an unchanged raw level is checked.
	always_comb begin
		raw_age = {1'b0, now} - {1'b0, raw_change_time_q};
		hold_len = {1'b0, raw_change_time_q} - {1'b0, press_start_time_q};
		commit = stable_known_q && (level == raw_state_q) && (raw_state_q != stable_state_q)
			&& !raw_age[TIME_BITS]
			&& (raw_age[TIME_BITS-1:0] >= TIME_BITS'(cfg.debounce));
		commit_press = (raw_state_q == cfg.pressed_level);
		is_long = !hold_len[TIME_BITS]
			&& (hold_len[TIME_BITS-1:0] >= TIME_BITS'(cfg.long_press));
		press_event = kdb_pkg::EV_NONE;
		if (commit && !commit_press && (stable_state_q == cfg.pressed_level)) begin
			press_event = is_long ? kdb_pkg::EV_LONG : kdb_pkg::EV_SHORT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_known_q <= 1'b0;
			stable_state_q <= 1'b0;
			raw_state_q <= 1'b0;
			raw_change_time_q <= '0;
			press_start_time_q <= '0;
		end else if (step) begin
			if (!stable_known_q) begin
				stable_known_q <= 1'b1;
				stable_state_q <= level;
				raw_state_q <= level;
				raw_change_time_q <= now;
				if (level == cfg.pressed_level) begin
					press_start_time_q <= now;
				end
			end else begin
				if (level != raw_state_q) begin
					raw_state_q <= level;
					raw_change_time_q <= now;
				end
				if (commit) begin
					stable_state_q <= raw_state_q;
					if (commit_press) begin
						press_start_time_q <= raw_change_time_q;
					end
				end
			end
		end
	end

endmodule

[design/key_debounce_long_short_press.sv]
// ----------------------------------------------------------------------------
// key_debounce_long_short_press
// Debounces a timestamped key level and classifies each release as a short
// or long press.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    key_level, sample_time
// out      output     out_valid / out_ready  press_event
// cfg      input      cfg_wr_en              cfg_index, cfg_wdata
//
// Every sample gives exactly one result, passed from the input register to the result register.
// One sample per cycle is sustained unless the output stalls; the limit is the
// decision-stage state update, which reads and writes the debounce state once per sample.
// A stall on the output holds the result register and then the input register.
// Reset restores the register defaults and forgets the stable level.
// ----------------------------------------------------------------------------
module key_debounce_long_short_press #(
	parameter int TIME_BITS = kdb_pkg::TIME_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic key_level,
	input logic [TIME_BITS-1:0] sample_time,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] press_event,
	input logic cfg_wr_en,
	input logic [kdb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input logic [kdb_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

	kdb_pkg::cfg_t cfg;
	kdb_pkg::event_t event_d;

	logic valid_s1;
	logic level_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic valid_s2;
	logic [1:0] event_s2;
	logic advance;

	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign press_event = event_s2;

	kdb_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg(cfg)
	);

	kdb_core #(
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.level(level_s1),
		.now(time_s1),
		.cfg(cfg),
		.press_event(event_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			level_s1 <= key_level;
			time_s1 <= sample_time;
		end
		if (advance) begin
			event_s2 <= event_d;
		end
	end

endmodule

[bench/tb_key_debounce_long_short_press.sv]
// ----------------------------------------------------------------------------
// tb_key_debounce_long_short_press
// Self-checking bench for the key debounce and press-length detector. Timed
// key samples go in over a valid/ready channel. A built-in predictor tracks
// the debounce state and computes the event that each sample should produce.
// Every result transaction is checked in order against those predictions.
// The run covers default, extreme and mid-range timing settings and both
// pressed levels, with random idling and output backpressure.
// ----------------------------------------------------------------------------
module tb_key_debounce_long_short_press;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TW = kdb_pkg::TIME_BITS_DEFAULT;
	localparam int QUIET_LIMIT = 3000;
	localparam logic [TW-1:0] TIME_MAX = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic key_level = 1'b0;
	logic [TW-1:0] sample_time = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] press_event;
	logic cfg_wr_en = 1'b0;
	logic [kdb_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [kdb_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

	// Register mirror and debounce state as the block should hold them.
	logic [kdb_pkg::CFG_DATA_BITS-1:0] set_debounce = kdb_pkg::DEBOUNCE_DEFAULT;
	logic [kdb_pkg::CFG_DATA_BITS-1:0] set_long_press = kdb_pkg::LONG_PRESS_DEFAULT;
	logic set_pressed = 1'b0;
	logic seen_first = 1'b0;
	logic stable_lvl = 1'b0;
	logic raw_lvl = 1'b0;
	logic [TW-1:0] raw_edge_ms = '0;
	logic [TW-1:0] press_start_ms = '0;

	kdb_pkg::event_t pending_events[$];
	kdb_pkg::event_t want_ev;
	int mismatches = 0;
	int unsigned samples_taken = 0;
	int quiet_cycles = 0;
	int src_idle_pct = 24;
	int sink_idle_pct = 59;
	int sink_hold = 0;
	logic [TW-1:0] key_clock = '0;

	key_debounce_long_short_press u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.key_level(key_level),
		.sample_time(sample_time),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.press_event(press_event),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned effective(input logic [kdb_pkg::CFG_DATA_BITS-1:0] val,
			input logic [kdb_pkg::CFG_DATA_BITS-1:0] dflt);
		return (val == '0) ? 32'(dflt) : 32'(val);
	endfunction

	function automatic kdb_pkg::event_t next_press_event(input logic lvl,
			input logic [TW-1:0] now);
		int unsigned db;
		int unsigned lp;
		logic was;
		kdb_pkg::event_t ev;
		db = effective(set_debounce, kdb_pkg::DEBOUNCE_DEFAULT);
		lp = effective(set_long_press, kdb_pkg::LONG_PRESS_DEFAULT);
		ev = kdb_pkg::EV_NONE;
		if (!seen_first) begin
			seen_first = 1'b1;
			stable_lvl = lvl;
			raw_lvl = lvl;
			raw_edge_ms = now;
			if (lvl == set_pressed) begin
				press_start_ms = now;
			end
			return kdb_pkg::EV_NONE;
		end
		if (lvl != raw_lvl) begin
			raw_lvl = lvl;
			raw_edge_ms = now;
		end
		if (raw_lvl != stable_lvl && now >= raw_edge_ms && (now - raw_edge_ms) >= db) begin
			was = stable_lvl;
			stable_lvl = raw_lvl;
			if (stable_lvl == set_pressed) begin
				press_start_ms = raw_edge_ms;
			end else if (was == set_pressed) begin
				if (raw_edge_ms >= press_start_ms && (raw_edge_ms - press_start_ms) >= lp) begin
					ev = kdb_pkg::EV_LONG;
				end else begin
					ev = kdb_pkg::EV_SHORT;
				end
			end
		end
		return ev;
	endfunction

	task automatic report_mismatch(input string what, input logic [1:0] got,
			input logic [1:0] want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				report_mismatch("unexpected result transaction", press_event, kdb_pkg::EV_NONE);
			end else begin
				want_ev = pending_events.pop_front();
				if (press_event !== want_ev) begin
					report_mismatch("press_event", press_event, want_ev);
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			pending_events.push_back(next_press_event(key_level, sample_time));
			samples_taken++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("key_debounce_long_short_press test failed");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	always @(negedge clk) begin
		if (sink_hold > 0) begin
			out_ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	task automatic offer_sample(input logic lvl, input logic [TW-1:0] t);
		int unsigned taken;
		if ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		taken = samples_taken;
		in_valid <= 1'b1;
		key_level <= lvl;
		sample_time <= t;
		do @(negedge clk); while (samples_taken == taken);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_settings(input logic [kdb_pkg::CFG_DATA_BITS-1:0] db,
			input logic [kdb_pkg::CFG_DATA_BITS-1:0] lp, input logic lvl);
		cfg_wr_en <= 1'b1;
		cfg_index <= kdb_pkg::REG_DEBOUNCE;
		cfg_wdata <= db;
		@(negedge clk);
		cfg_index <= kdb_pkg::REG_LONG_PRESS;
		cfg_wdata <= lp;
		@(negedge clk);
		cfg_index <= kdb_pkg::REG_PRESSED_LEVEL;
		cfg_wdata <= {{(kdb_pkg::CFG_DATA_BITS-1){1'b0}}, lvl};
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		set_debounce = db;
		set_long_press = lp;
		set_pressed = lvl;
	endtask

	// Holds one level for dur ms, starting with an edge at the current key clock.
	task automatic hold_level(input logic lvl, input int unsigned dur);
		int unsigned k;
		offer_sample(lvl, key_clock);
		k = $urandom_range(1, 3);
		for (int unsigned i = 1; i <= k; i++) begin
			offer_sample(lvl, key_clock + TW'(dur * i / k));
		end
		key_clock = key_clock + TW'(dur);
	endtask

	// Contact bounce: pulses shorter than the debounce time that never commit.
	task automatic chatter(input logic lvl, input int unsigned db);
		repeat ($urandom_range(0, 2)) begin
			offer_sample(lvl, key_clock);
			key_clock = key_clock + TW'($urandom_range(0, db - 1));
			offer_sample(!lvl, key_clock);
			key_clock = key_clock + TW'($urandom_range(0, db - 1));
		end
	endtask

	task automatic play_press_traffic(input int unsigned n_items);
		int unsigned first;
		int unsigned db;
		int unsigned lp;
		int unsigned hold;
		int unsigned pick;
		logic on_lvl;
		first = samples_taken;
		db = effective(set_debounce, kdb_pkg::DEBOUNCE_DEFAULT);
		lp = effective(set_long_press, kdb_pkg::LONG_PRESS_DEFAULT);
		on_lvl = set_pressed;
		while (samples_taken - first < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				case ($urandom_range(0, 4))
					0: hold = lp - 1;
					1: hold = lp;
					2: hold = lp + 1;
					3: hold = $urandom_range(0, db);
					default: hold = $urandom_range(db, db + 2 * lp);
				endcase
				chatter(on_lvl, db);
				hold_level(on_lvl, hold);
				chatter(!on_lvl, db);
				hold_level(!on_lvl, $urandom_range(db, 3 * db));
			end else if (pick < 87) begin
				key_clock = key_clock + TW'($urandom_range(0, db));
				offer_sample(1'($urandom_range(0, 1)), key_clock);
			end else if (pick < 95) begin
				key_clock = key_clock - TW'($urandom_range(0, 2 * db));
				offer_sample(1'($urandom_range(0, 1)), key_clock);
			end else begin
				key_clock = TW'({$urandom, $urandom});
				offer_sample(1'($urandom_range(0, 1)), key_clock);
			end
		end
	endtask

	// Reset settings: debounce 30 ms, long press 800 ms, pressed level 0.
	task automatic test_directed_presses();
		offer_sample(1'b0, 48'd100);
		offer_sample(1'b1, 48'd1000);
		offer_sample(1'b1, 48'd1029);
		offer_sample(1'b1, 48'd1030);
		offer_sample(1'b0, 48'd2000);
		offer_sample(1'b0, 48'd2030);
		offer_sample(1'b1, 48'd2500);
		offer_sample(1'b0, 48'd2510);
		offer_sample(1'b1, 48'd2799);
		offer_sample(1'b1, 48'd2829);
		offer_sample(1'b0, 48'd3000);
		offer_sample(1'b0, 48'd3030);
		offer_sample(1'b1, 48'd3800);
		offer_sample(1'b1, 48'd3830);
		// The clock steps back while the press is still settling.
		offer_sample(1'b0, 48'd4000);
		offer_sample(1'b0, 48'd3990);
		offer_sample(1'b0, 48'd4030);
		// The release edge lies before the press edge.
		offer_sample(1'b1, 48'd0);
		offer_sample(1'b1, 48'd40);
		offer_sample(1'b0, TIME_MAX - 48'd2000);
		offer_sample(1'b0, TIME_MAX - 48'd1970);
		offer_sample(1'b1, TIME_MAX - 48'd1000);
		offer_sample(1'b1, TIME_MAX);
	endtask

	task automatic test_fast_timing();
		wait_results_done();
		apply_settings(16'd1, 16'd1, 1'b1);
		play_press_traffic(150);
	endtask

	task automatic test_slow_timing();
		wait_results_done();
		apply_settings(16'hFFFF, 16'hFFFF, 1'b0);
		play_press_traffic(150);
	endtask

	task automatic test_zero_means_default();
		wait_results_done();
		apply_settings(16'd0, 16'd0, 1'b1);
		play_press_traffic(200);
	endtask

	task automatic test_output_holdoff();
		sink_hold = 60;
		play_press_traffic(30);
		wait_results_done();
	endtask

	task automatic test_mid_timing();
		wait_results_done();
		apply_settings(16'd7, 16'd100, 1'b0);
		play_press_traffic(300);
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_presses();
		test_fast_timing();
		test_slow_timing();
		src_idle_pct = 59;
		sink_idle_pct = 24;
		test_zero_means_default();
		test_output_holdoff();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_mid_timing();
		wait_results_done();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && pending_events.size() == 0) begin
			$display("key_debounce_long_short_press test passed");
		end else begin
			$display("key_debounce_long_short_press test failed");
		end
		$finish;
	end

endmodule

[filelist.f]
design/kdb_pkg.sv
design/kdb_cfg.sv
design/kdb_core.sv
design/key_debounce_long_short_press.sv
bench/tb_key_debounce_long_short_press.sv
